### hdl/ceatr_pkg.sv
// shared types and constants of the emulated atr builder
package ceatr_pkg;

  // atr framing bytes
  localparam logic [7:0] ATR_TS      = 8'h3B;
  localparam logic [7:0] ATR_T0_BASE = 8'h80;
  localparam logic [7:0] ATR_TD1     = 8'h80;
  localparam logic [7:0] ATR_TD2     = 8'h01;
  localparam logic [7:0] ATR_T0_ATQB = 8'h88;

  // t0 interface byte flags of the ats
  localparam int unsigned TA_BIT = 6;
  localparam int unsigned TB_BIT = 5;
  localparam int unsigned TC_BIT = 4;

  // atqb frame facts
  localparam logic [7:0] ATQB_LEN      = 8'd7;
  localparam logic [7:0] ATQB_LAST_POS = 8'd6;
  localparam logic [8:0] ATQB_TOTAL    = 9'd13;

  // ats frame facts
  localparam logic [7:0] ATS_MIN_LEN   = 8'd2;
  localparam logic [2:0] HIST_START_RST = 3'd2;
  localparam logic [8:0] ATR_HDR_TOTAL = 9'd5;

  // source kinds
  localparam logic KIND_ATS  = 1'b0;
  localparam logic KIND_ATQB = 1'b1;

  // run descriptor sizing
  localparam int unsigned RUN_MAX   = 5;
  localparam int unsigned RUN_CNT_W = 3;

  // default depth of the run queue
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       action;
    logic       frame_start;
    logic [7:0] data_byte;
    logic [7:0] card_id;
  } in_item_t;

  typedef struct packed {
    logic [7:0] atr_byte;
    logic       atr_end;
    logic [8:0] atr_total;
    logic       run_last;
  } out_item_t;

  // all results caused by one input item
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_CNT_W-1:0]    cnt;
    logic                    is_end;
    logic [8:0]              total;
  } run_t;

endpackage

### hdl/ceatr_front.sv
// front end: frame parsing and run descriptor generation
module ceatr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ceatr_pkg::in_item_t  in_item,
  input  logic                 accept,
  output ceatr_pkg::run_t      run,
  output logic                 run_valid
);
  import ceatr_pkg::*;

  logic       kind_r,   kind_nxt;
  logic [7:0] pos_r,    pos_nxt;
  logic [7:0] flen_r,   flen_nxt;
  logic [2:0] hstart_r, hstart_nxt;
  logic [7:0] hcount_r, hcount_nxt;
  logic [7:0] acc_r,    acc_nxt;
  logic       fin_r,    fin_nxt;

  // frame state update and run contents
  always_comb begin
    logic [7:0] b;
    logic [7:0] pos_inc;
    logic [2:0] off;
    logic [7:0] hl;
    logic [7:0] t0;
    logic [7:0] acc_h;
    logic [7:0] acc_x;
    logic [7:0] nib;
    b          = in_item.data_byte;
    pos_inc    = pos_r + 8'd1;
    off        = HIST_START_RST + {2'b0, b[TA_BIT]} + {2'b0, b[TB_BIT]} + {2'b0, b[TC_BIT]};
    hl         = ({5'b0, off} < flen_r) ? (flen_r - {5'b0, off}) : 8'd0;
    t0         = ATR_T0_BASE | hl;
    acc_h      = t0 ^ ATR_TD1 ^ ATR_TD2;
    acc_x      = acc_r ^ b;
    nib        = {4'b0, in_item.card_id[7:4]};
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    flen_nxt   = flen_r;
    hstart_nxt = hstart_r;
    hcount_nxt = hcount_r;
    acc_nxt    = acc_r;
    fin_nxt    = fin_r;
    run        = '0;
    if (in_item.frame_start) begin
      kind_nxt   = in_item.action;
      pos_nxt    = 8'd0;
      fin_nxt    = 1'b0;
      hstart_nxt = HIST_START_RST;
      hcount_nxt = 8'd0;
      if (in_item.action == KIND_ATS) begin
        flen_nxt = b;
        // too short for t0: empty historical part right away
        if (b < ATS_MIN_LEN) begin
          run.bytes[0] = ATR_TS;
          run.bytes[1] = ATR_T0_BASE;
          run.bytes[2] = ATR_TD1;
          run.bytes[3] = ATR_TD2;
          run.bytes[4] = ATR_T0_BASE ^ ATR_TD1 ^ ATR_TD2;
          run.cnt      = 3'd5;
          run.is_end   = 1'b1;
          run.total    = ATR_HDR_TOTAL;
          acc_nxt      = ATR_T0_BASE ^ ATR_TD1 ^ ATR_TD2;
          fin_nxt      = 1'b1;
        end
      end else begin
        flen_nxt     = ATQB_LEN;
        run.bytes[0] = ATR_TS;
        run.bytes[1] = ATR_T0_ATQB;
        run.bytes[2] = ATR_TD1;
        run.bytes[3] = ATR_TD2;
        run.bytes[4] = b;
        run.cnt      = 3'd5;
        acc_nxt      = ATR_T0_ATQB ^ ATR_TD1 ^ ATR_TD2 ^ b;
      end
    end else if (!fin_r) begin
      pos_nxt = pos_inc;
      if (kind_r == KIND_ATS) begin
        if (pos_inc == 8'd1) begin
          // t0 byte: skip interface bytes, emit header
          hstart_nxt   = off;
          hcount_nxt   = hl;
          acc_nxt      = acc_h;
          run.bytes[0] = ATR_TS;
          run.bytes[1] = t0;
          run.bytes[2] = ATR_TD1;
          run.bytes[3] = ATR_TD2;
          run.cnt      = 3'd4;
          if (hl == 8'd0) begin
            run.bytes[4] = acc_h;
            run.cnt      = 3'd5;
            run.is_end   = 1'b1;
            run.total    = ATR_HDR_TOTAL;
            fin_nxt      = 1'b1;
          end
        end else if (pos_inc >= {5'b0, hstart_r}) begin
          // historical byte, tck after the last one
          acc_nxt      = acc_x;
          run.bytes[0] = b;
          run.cnt      = 3'd1;
          if (pos_inc == flen_r - 8'd1) begin
            run.bytes[1] = acc_x;
            run.cnt      = 3'd2;
            run.is_end   = 1'b1;
            run.total    = ATR_HDR_TOTAL + {1'b0, hcount_r};
            fin_nxt      = 1'b1;
          end
        end
      end else begin
        acc_nxt      = acc_x;
        run.bytes[0] = b;
        run.cnt      = 3'd1;
        // seventh atqb byte: cid nibble and tck follow
        if (pos_inc >= ATQB_LAST_POS) begin
          acc_nxt      = acc_x ^ nib;
          run.bytes[1] = nib;
          run.bytes[2] = acc_x ^ nib;
          run.cnt      = 3'd3;
          run.is_end   = 1'b1;
          run.total    = ATQB_TOTAL;
          fin_nxt      = 1'b1;
        end
      end
    end
  end

  assign run_valid = accept && (run.cnt != '0);

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_ATS;
      pos_r    <= 8'd0;
      flen_r   <= 8'd0;
      hstart_r <= HIST_START_RST;
      hcount_r <= 8'd0;
      acc_r    <= 8'd0;
      fin_r    <= 1'b1;
    end else if (accept) begin
      kind_r   <= kind_nxt;
      pos_r    <= pos_nxt;
      flen_r   <= flen_nxt;
      hstart_r <= hstart_nxt;
      hcount_r <= hcount_nxt;
      acc_r    <= acc_nxt;
      fin_r    <= fin_nxt;
    end
  end

endmodule

### hdl/ceatr_queue.sv
// short queue of run descriptors between front and back
module ceatr_queue #(
  parameter int unsigned DEPTH = ceatr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  ceatr_pkg::run_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output ceatr_pkg::run_t rd_data,
  output logic            rd_valid
);
  import ceatr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  run_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full     = (count_r == CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hdl/ceatr_back.sv
// back end: plays each run out one atr byte at a time
module ceatr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ceatr_pkg::run_t      q_data,
  input  logic                 q_valid,
  output logic                 q_pop,
  output ceatr_pkg::out_item_t out_item,
  output logic                 empty,
  input  logic                 pop
);
  import ceatr_pkg::*;

  run_t                 cur_r;
  logic                 valid_r;
  logic [RUN_CNT_W-1:0] idx_r;
  logic                 last;
  logic                 take;

  assign last  = (idx_r == cur_r.cnt - RUN_CNT_W'(1));
  assign take  = !valid_r || (pop && last);
  assign q_pop = take && q_valid;
  assign empty = !valid_r;

  // result fields of the current byte
  always_comb begin
    out_item.atr_byte  = cur_r.bytes[idx_r];
    out_item.run_last  = last;
    out_item.atr_end   = cur_r.is_end && last;
    out_item.atr_total = (cur_r.is_end && last) ? cur_r.total : 9'd0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (take) begin
      valid_r <= q_valid;
      idx_r   <= '0;
    end else if (pop) begin
      idx_r   <= idx_r + RUN_CNT_W'(1);
    end
  end

  // current run descriptor
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

endmodule

### hdl/contactless_emulated_atr_builder.sv
// top level of the emulated contact atr builder
// an item's atr bytes are registered in the run queue, then in the back end
// throughput: one input byte per cycle unless full; one atr byte per cycle
//   out unless empty, up to five per byte in, run queue of QUEUE_DEPTH runs
// reset: synchronous, empties queue and output, parser waits for a frame start
module contactless_emulated_atr_builder #(
  parameter int unsigned QUEUE_DEPTH = ceatr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ceatr_pkg::in_item_t  in_item,
  input  logic                 push,
  output logic                 full,
  output ceatr_pkg::out_item_t out_item,
  output logic                 empty,
  input  logic                 pop
);
  import ceatr_pkg::*;

  run_t run;
  logic run_valid;
  run_t q_data;
  logic q_valid;
  logic q_pop;
  logic accept;

  assign accept = push && !full;

  // parser
  ceatr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .accept    (accept),
    .run       (run),
    .run_valid (run_valid)
  );

  // run queue
  ceatr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (run_valid),
    .wr_data  (run),
    .full     (full),
    .rd_en    (q_pop),
    .rd_data  (q_data),
    .rd_valid (q_valid)
  );

  // byte sequencer
  ceatr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

endmodule
